### sv/hsva_pkg.sv
// Shared types and constants for the HSVA to RGBA pixel converter.
// No dependencies; used by hsva_hue_split and hsva_to_rgba_pixel.
package hsva_pkg;

  // Hue sectors of 60 degrees, in color-wheel order
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  typedef struct packed {
    sector_e     sector;
    logic [15:0] frac;    // position inside the sector, 16-bit fraction
  } hue_split_t;

  localparam logic [5:0]  DEG_PER_SECTOR = 6'd60;
  localparam logic [2:0]  SECTOR_COUNT   = 3'd6;
  // floor(2^k / d) reciprocals; the estimate is low by at most one
  localparam logic [16:0] RECIP60_K22    = 17'd69905;
  localparam logic [22:0] RECIP60_K28    = 23'd4473924;
  localparam logic [11:0] RECIP6_K14     = 12'd2730;

  localparam logic [8:0]  UNIT_SCALE     = 9'd256;
  localparam logic [7:0]  LEVEL_MAX      = 8'd255;
  localparam logic [16:0] FRAC_ONE       = 17'h10000;
  localparam logic [24:0] LEVEL_ONE      = 25'h1000000;

endpackage

### sv/hsva_hue_split.sv
// Hue decomposition: sector index and in-sector fraction, four register stages.
// Depends on hsva_pkg.
module hsva_hue_split #(
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [15:0]         hue_i,
  output hsva_pkg::hue_split_t split_o
);
  import hsva_pkg::*;

  localparam int unsigned FRAC_SHIFT = 16 - HUE_FRACTION_BITS;
  localparam logic [15:0] LO_MASK    = 16'((32'd1 << HUE_FRACTION_BITS) - 32'd1);

  // stage A: whole degrees and reciprocal product
  logic [15:0] deg_q, lo_a_q;
  logic [32:0] prod_a_q;
  // stage B: degrees / 60 and remainder
  logic [10:0] quo_b_q;
  logic [5:0]  r60_q;
  logic [15:0] lo_b_q;
  // stage C: reciprocal products for the fraction and for quotient mod 6
  logic [21:0] x_q;
  logic [43:0] prod_c_q;
  logic [10:0] quo_c_q;
  logic [22:0] prod_s_q;
  // stage D
  hue_split_t  split_q;

  logic [15:0] deg_d;
  logic [32:0] prod_a_d;
  logic [10:0] q0;
  logic [16:0] qx60, r_a;
  logic [10:0] quo_b_d;
  logic [5:0]  r60_d;
  logic [15:0] rem;
  logic [21:0] x_d;
  logic [43:0] prod_c_d;
  logic [22:0] prod_s_d;
  logic [15:0] f0;
  logic [21:0] fx60, rf;
  logic [7:0]  s0;
  logic [10:0] sx6, r6;
  logic [2:0]  sec;
  hue_split_t  split_d;

  always_comb begin
    deg_d    = hue_i >> HUE_FRACTION_BITS;
    prod_a_d = 33'(deg_d) * 33'(RECIP60_K22);
  end

  always_comb begin
    q0   = prod_a_q[32:22];
    qx60 = 17'(q0) * 17'(DEG_PER_SECTOR);
    r_a  = {1'b0, deg_q} - qx60;
    if (r_a >= 17'(DEG_PER_SECTOR)) begin
      quo_b_d = q0 + 11'd1;
      r60_d   = 6'(r_a - 17'(DEG_PER_SECTOR));
    end else begin
      quo_b_d = q0;
      r60_d   = r_a[5:0];
    end
  end

  always_comb begin
    rem      = (16'(r60_q) << HUE_FRACTION_BITS) | lo_b_q;
    x_d      = 22'(rem) << FRAC_SHIFT;
    prod_c_d = 44'(x_d) * 44'(RECIP60_K28);
    prod_s_d = 23'(quo_b_q) * 23'(RECIP6_K14);
  end

  always_comb begin
    f0   = prod_c_q[43:28];
    fx60 = 22'(f0) * 22'(DEG_PER_SECTOR);
    rf   = x_q - fx60;
    s0   = prod_s_q[21:14];
    sx6  = 11'(s0) * 11'(SECTOR_COUNT);
    r6   = quo_c_q - sx6;
    if (r6 >= 11'(SECTOR_COUNT)) begin
      sec = 3'(r6 - 11'(SECTOR_COUNT));
    end else begin
      sec = r6[2:0];
    end
    split_d.sector = sector_e'(sec);
    split_d.frac   = (rf >= 22'(DEG_PER_SECTOR)) ? f0 + 16'd1 : f0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deg_q    <= deg_d;
      lo_a_q   <= hue_i & LO_MASK;
      prod_a_q <= prod_a_d;
      quo_b_q  <= quo_b_d;
      r60_q    <= r60_d;
      lo_b_q   <= lo_a_q;
      x_q      <= x_d;
      prod_c_q <= prod_c_d;
      quo_c_q  <= quo_b_q;
      prod_s_q <= prod_s_d;
      split_q  <= split_d;
    end
  end

  assign split_o = split_q;

endmodule

### sv/hsva_to_rgba_pixel.sv
// HSVA to RGBA pixel converter, top level: input clamps, level products, routing.
// Depends on hsva_pkg and hsva_hue_split.

// One pixel per clock while the output is not blocked. A request passes through the
// four hue-split stages, stage 5 and the output register. The pipeline has one
// shared enable: when the output register holds a result that is not taken, every
// stage holds and in_ready_o drops, so in_ready_o follows out_ready_i combinationally.
// Hue is split into sector and fraction by constant-reciprocal products over four
// stages, then one stage forms the f*sat products and the last stage the q and t
// levels and channel routing.
module hsva_to_rgba_pixel #(
  parameter int unsigned HUE_FRACTION_BITS = 6
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       hue_angle_i,
  input  logic [8:0]        saturation_i,
  input  logic [8:0]        brightness_i,
  input  logic signed [9:0] opacity_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        alpha_out_o
);
  import hsva_pkg::*;

  localparam int unsigned SPLIT_STAGES = 4;
  localparam int unsigned STAGES       = SPLIT_STAGES + 2;

  logic              advance;
  logic [STAGES-1:0] vld_q;
  hue_split_t        split;

  // side data carried next to the hue split
  logic [8:0]  sat_q   [SPLIT_STAGES];
  logic [15:0] bigv_q  [SPLIT_STAGES];
  logic [7:0]  alpha_q [SPLIT_STAGES];

  logic [8:0]  sat_c, val_c, alpha_c;
  logic [15:0] bigv_d;
  logic [16:0] alpha_prod;

  // stage 5
  logic [24:0] fs_d, ft_d, pp_d;
  logic [16:0] frac_inv;
  logic [24:0] fs_q, ft_q;
  logic [7:0]  lp5_q, lv5_q, alpha5_q;
  logic [15:0] bigv5_q;
  sector_e     sector5_q;

  // output stage
  logic [24:0] term_lq, term_lt;
  logic [40:0] prod_lq, prod_lt;
  logic [7:0]  lq, lt;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q, alpha_out_q;

  assign advance    = !vld_q[STAGES-1] || out_ready_i;
  assign in_ready_o = advance;

  always_comb begin
    sat_c = (saturation_i > UNIT_SCALE) ? UNIT_SCALE : saturation_i;
    val_c = (brightness_i > UNIT_SCALE) ? UNIT_SCALE : brightness_i;
    if (opacity_i < 10'sd0) begin
      alpha_c = 9'd0;
    end else if (opacity_i > $signed({1'b0, UNIT_SCALE})) begin
      alpha_c = UNIT_SCALE;
    end else begin
      alpha_c = opacity_i[8:0];
    end
    bigv_d     = 16'(val_c) * 16'(LEVEL_MAX);
    alpha_prod = 17'(alpha_c) * 17'(LEVEL_MAX);
  end

  hsva_hue_split #(
    .HUE_FRACTION_BITS(HUE_FRACTION_BITS)
  ) u_hue_split (
    .clk_i  (clk_i),
    .en_i   (advance),
    .hue_i  (hue_angle_i),
    .split_o(split)
  );

  always_comb begin
    frac_inv = FRAC_ONE - 17'(split.frac);
    fs_d     = 25'(split.frac) * 25'(sat_q[SPLIT_STAGES-1]);
    ft_d     = 25'(frac_inv) * 25'(sat_q[SPLIT_STAGES-1]);
    pp_d     = 25'(bigv_q[SPLIT_STAGES-1]) * 25'(UNIT_SCALE - sat_q[SPLIT_STAGES-1]);
  end

  always_comb begin
    term_lq = LEVEL_ONE - fs_q;
    term_lt = LEVEL_ONE - ft_q;
    prod_lq = 41'(bigv5_q) * 41'(term_lq);
    prod_lt = 41'(bigv5_q) * 41'(term_lt);
    lq      = prod_lq[39:32];
    lt      = prod_lt[39:32];
    case (sector5_q)
      SEC_RED_YEL: begin
        red_d = lv5_q; green_d = lt;    blue_d = lp5_q;
      end
      SEC_YEL_GRN: begin
        red_d = lq;    green_d = lv5_q; blue_d = lp5_q;
      end
      SEC_GRN_CYN: begin
        red_d = lp5_q; green_d = lv5_q; blue_d = lt;
      end
      SEC_CYN_BLU: begin
        red_d = lp5_q; green_d = lq;    blue_d = lv5_q;
      end
      SEC_BLU_MAG: begin
        red_d = lt;    green_d = lp5_q; blue_d = lv5_q;
      end
      default: begin
        red_d = lv5_q; green_d = lp5_q; blue_d = lq;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (advance) begin
      vld_q <= {vld_q[STAGES-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sat_q[0]   <= sat_c;
      bigv_q[0]  <= bigv_d;
      alpha_q[0] <= alpha_prod[15:8];
      for (int i = 1; i < SPLIT_STAGES; i++) begin
        sat_q[i]   <= sat_q[i-1];
        bigv_q[i]  <= bigv_q[i-1];
        alpha_q[i] <= alpha_q[i-1];
      end
      fs_q        <= fs_d;
      ft_q        <= ft_d;
      lp5_q       <= pp_d[23:16];
      lv5_q       <= bigv_q[SPLIT_STAGES-1][15:8];
      bigv5_q     <= bigv_q[SPLIT_STAGES-1];
      alpha5_q    <= alpha_q[SPLIT_STAGES-1];
      sector5_q   <= split.sector;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
      alpha_out_q <= alpha5_q;
    end
  end

  assign out_valid_o = vld_q[STAGES-1];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_out_o = alpha_out_q;

  // a blocked output freezes every stage
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(vld_q))
    else $error("pipeline moved while output was blocked");

  // p never exceeds v
  a_p_below_v: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STAGES-2] |-> (lp5_q <= lv5_q))
    else $error("p level above v level");

  // f*sat terms stay within one, else the q/t subtraction wraps
  a_terms_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[STAGES-2] |-> ((fs_q <= LEVEL_ONE) && (ft_q <= LEVEL_ONE)))
    else $error("fraction-saturation product out of range");

endmodule

### tb/tb_hsva_to_rgba_pixel.sv
// Testbench for hsva_to_rgba_pixel: directed and random pixel requests with
// random idling on both valid/ready channels, checked against a built-in predictor.
// Depends on hsva_pkg and the hsva_to_rgba_pixel RTL.
module tb_hsva_to_rgba_pixel;
  import hsva_pkg::*;

  localparam int unsigned HUE_FRAC_BITS = 6;
  localparam int unsigned SECTOR_UNITS  = 60 << HUE_FRAC_BITS;
  localparam int unsigned TAIL_CYCLES   = 20;

  typedef struct {
    logic [15:0]       hue;
    logic [8:0]        sat;
    logic [8:0]        bri;
    logic signed [9:0] opa;
  } pixel_req_t;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic [15:0]       hue_angle_i  = '0;
  logic [8:0]        saturation_i = '0;
  logic [8:0]        brightness_i = '0;
  logic signed [9:0] opacity_i    = '0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic [7:0]        red_o;
  logic [7:0]        green_o;
  logic [7:0]        blue_o;
  logic [7:0]        alpha_out_o;

  pixel_req_t pending_reqs[$];
  rgba_t      rgba_expected[$];
  pixel_req_t req_in_flight;
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  hsva_to_rgba_pixel #(
    .HUE_FRACTION_BITS(HUE_FRAC_BITS)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .hue_angle_i (hue_angle_i),
    .saturation_i(saturation_i),
    .brightness_i(brightness_i),
    .opacity_i   (opacity_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_out_o (alpha_out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Fixed-point HSVA to RGBA, six-sector routing
  function automatic rgba_t convert_hsva(input pixel_req_t px);
    longint unsigned hue, sat, bri, rem, frac, big_v, lv, lp, lq, lt;
    longint signed   opa;
    sector_e         sec;
    rgba_t           res;
    hue   = 64'(px.hue);
    sat   = 64'((px.sat > UNIT_SCALE) ? UNIT_SCALE : px.sat);
    bri   = 64'((px.bri > UNIT_SCALE) ? UNIT_SCALE : px.bri);
    sec   = sector_e'(3'((hue / SECTOR_UNITS) % 6));
    rem   = hue % SECTOR_UNITS;
    frac  = (rem * FRAC_ONE) / SECTOR_UNITS;
    big_v = bri * LEVEL_MAX;
    lv    = big_v >> 8;
    lp    = (big_v * (UNIT_SCALE - sat)) >> 16;
    lq    = (big_v * (LEVEL_ONE - frac * sat)) >> 32;
    lt    = (big_v * (LEVEL_ONE - (FRAC_ONE - frac) * sat)) >> 32;
    case (sec)
      SEC_RED_YEL: begin res.red = lv[7:0]; res.green = lt[7:0]; res.blue = lp[7:0]; end
      SEC_YEL_GRN: begin res.red = lq[7:0]; res.green = lv[7:0]; res.blue = lp[7:0]; end
      SEC_GRN_CYN: begin res.red = lp[7:0]; res.green = lv[7:0]; res.blue = lt[7:0]; end
      SEC_CYN_BLU: begin res.red = lp[7:0]; res.green = lq[7:0]; res.blue = lv[7:0]; end
      SEC_BLU_MAG: begin res.red = lt[7:0]; res.green = lp[7:0]; res.blue = lv[7:0]; end
      default:     begin res.red = lv[7:0]; res.green = lp[7:0]; res.blue = lq[7:0]; end
    endcase
    opa = 64'(px.opa);
    if (opa < 0) opa = 0;
    if (opa > UNIT_SCALE) opa = 64'(UNIT_SCALE);
    opa = (opa * LEVEL_MAX) >> 8;
    res.alpha = opa[7:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic queue_req(input logic [15:0] hue, input logic [8:0] sat,
                           input logic [8:0] bri, input logic signed [9:0] opa);
    pixel_req_t px;
    px.hue = hue;
    px.sat = sat;
    px.bri = bri;
    px.opa = opa;
    pending_reqs.push_back(px);
    queued_cnt++;
  endtask

  task automatic queue_random_req();
    logic [15:0]       hue;
    logic [8:0]        sat;
    logic [8:0]        bri;
    logic signed [9:0] opa;
    // a share of hues sits right at sector edges
    if ($urandom_range(99) < 25)
      hue = 16'($urandom_range(16) * SECTOR_UNITS + $urandom_range(4) - 2);
    else
      hue = 16'($urandom);
    sat = 9'(($urandom_range(99) < 80) ? $urandom_range(256) : $urandom_range(511));
    bri = 9'(($urandom_range(99) < 80) ? $urandom_range(256) : $urandom_range(511));
    opa = 10'(($urandom_range(99) < 50) ? $urandom_range(300) : $urandom_range(1023));
    queue_req(hue, sat, bri, opa);
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    pixel_req_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rgba_expected.push_back(convert_hsva(req_in_flight));
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_reqs.pop_front();
          req_in_flight = nxt;
          in_valid_i   <= 1'b1;
          hue_angle_i  <= nxt.hue;
          saturation_i <= nxt.sat;
          brightness_i <= nxt.bri;
          opacity_i    <= nxt.opa;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : rgba_monitor
    rgba_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (rgba_expected.size() == 0) begin
          flag_mismatch($sformatf("unexpected result r=%0d g=%0d b=%0d a=%0d",
                                  red_o, green_o, blue_o, alpha_out_o));
        end else begin
          want = rgba_expected.pop_front();
          if (red_o !== want.red)
            flag_mismatch($sformatf("red: got %0d, expected %0d", red_o, want.red));
          if (green_o !== want.green)
            flag_mismatch($sformatf("green: got %0d, expected %0d", green_o, want.green));
          if (blue_o !== want.blue)
            flag_mismatch($sformatf("blue: got %0d, expected %0d", blue_o, want.blue));
          if (alpha_out_o !== want.alpha)
            flag_mismatch($sformatf("alpha: got %0d, expected %0d", alpha_out_o,
                                    want.alpha));
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin : run_stimulus
    int unsigned phase_items[3];
    int unsigned send_pct[3];
    int unsigned recv_pct[3];
    phase_items = '{600, 600, 630};
    send_pct    = '{25, 84, 0};
    recv_pct    = '{84, 25, 0};

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners: hue sector edges and wrap, clamps on saturation, brightness and opacity
    queue_req(16'd0, 9'd256, 9'd256, 10'sd256);
    queue_req(16'd65535, 9'd256, 9'd256, 10'sd511);
    queue_req(16'd3839, 9'd256, 9'd256, -10'sd512);
    queue_req(16'd3840, 9'd256, 9'd256, -10'sd1);
    queue_req(16'd7680, 9'd128, 9'd256, 10'sd0);
    queue_req(16'd11520, 9'd256, 9'd200, 10'sd257);
    queue_req(16'd15360, 9'd256, 9'd256, 10'sd128);
    queue_req(16'd19200, 9'd256, 9'd256, 10'sd255);
    queue_req(16'd23039, 9'd256, 9'd256, 10'sd1);
    queue_req(16'd23040, 9'd256, 9'd256, 10'sd256);
    queue_req(16'd46080, 9'd100, 9'd100, 10'sd100);
    queue_req(16'd1920, 9'd0, 9'd256, 10'sd256);
    queue_req(16'd1920, 9'd511, 9'd256, 10'sd256);
    queue_req(16'd1920, 9'd257, 9'd511, 10'sd256);
    queue_req(16'd5000, 9'd256, 9'd0, 10'sd256);
    queue_req(16'd9000, 9'd256, 9'd257, 10'sd300);
    queue_req(16'd13000, 9'd511, 9'd511, -10'sd256);
    queue_req(16'd17000, 9'd1, 9'd1, 10'sd2);
    queue_req(16'd21000, 9'd255, 9'd255, 10'sd511);
    queue_req(16'd32768, 9'd170, 9'd85, -10'sd512);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_pct[ph];
      recv_idle_pct = recv_pct[ph];
      for (int n = 0; n < phase_items[ph]; n++) queue_random_req();
      wait (accepted_cnt == queued_cnt);
    end

    wait (rgba_expected.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0 && rgba_expected.size() == 0) begin
      $display("hsva_to_rgba_pixel verification clean");
    end else begin
      $display("hsva_to_rgba_pixel verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("hsva_to_rgba_pixel verification failed");
    $finish;
  end

endmodule

### sim.f
sv/hsva_pkg.sv
sv/hsva_hue_split.sv
sv/hsva_to_rgba_pixel.sv
tb/tb_hsva_to_rgba_pixel.sv
